// File: rtl/rthc_pkg.sv
// Package for the RGB to HLS converter: widths, constants and the per-stage
// pipeline record shared by the divider cells and the top level.
// No dependencies.
package rthc_pkg;

    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned PIXEL_W = 3 * CHAN_W;
    // Numerators reach 255*6*255 for hue; divisors reach 6*255.
    localparam int unsigned NUM_W   = 19;
    localparam int unsigned DEN_W   = 11;
    localparam int unsigned QUO_W   = 8;

    // Hue sector, picked by the channel that holds the maximum.
    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } sector_t;

    // One long division in flight: remainder, divisor and quotient bits so far.
    typedef struct packed {
        logic [DEN_W:0]     rem;
        logic [NUM_W-1:0]   num;
        logic [DEN_W-1:0]   den;
        logic [QUO_W-1:0]   quo;
    } div_lane_t;

    // Everything a cell hands to its neighbour each time the chain advances.
    typedef struct packed {
        logic               valid;
        logic [CHAN_W-1:0]  lightness;
        div_lane_t          hue;
        div_lane_t          sat;
    } cell_data_t;

endpackage

// File: rtl/rgb_to_hls_convert_core.sv
// RGB to hue/lightness/saturation converter, one pixel per clock unless stalled.
// A pixel passes two front stages (channel sort, then the 255x numerators), then
// a chain of 19 restoring-division cells, one quotient bit per cell. The whole
// chain stalls together when m_axis_tvalid is high and m_axis_tready is low.
// Depends on rthc_pkg and rthc_div_cell.
module rgb_to_hls_convert_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // pixel_rgb[23:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // hue[7:0], lightness[15:8], saturation[23:16]
);

    localparam int unsigned NCELL = rthc_pkg::NUM_W;

    logic advance;
    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;

    // Stage A: sort channels.
    logic [7:0] r, g, b, hi, lo;
    rthc_pkg::sector_t sect;
    logic [8:0] hue_d;
    assign r = s_axis_tdata[7:0];
    assign g = s_axis_tdata[15:8];
    assign b = s_axis_tdata[23:16];

    always_comb begin
        hi = (r > g) ? r : g;
        hi = (hi > b) ? hi : b;
        lo = (r < g) ? r : g;
        lo = (lo < b) ? lo : b;
        // channel difference kept as a 9-bit signed value
        priority if (b == hi) begin
            sect = rthc_pkg::SECT_BLUE; hue_d = {1'b0, r} - {1'b0, g};
        end else if (g == hi) begin
            sect = rthc_pkg::SECT_GREEN; hue_d = {1'b0, b} - {1'b0, r};
        end else begin
            sect = rthc_pkg::SECT_RED; hue_d = {1'b0, g} - {1'b0, b};
        end
    end

    logic       a_valid_reg;
    logic [7:0] a_diff_reg;
    logic [8:0] a_hued_reg;
    logic [8:0] a_sum_reg;
    rthc_pkg::sector_t a_sect_reg;
    logic       a_gt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg <= s_axis_tvalid;
        end
        if (advance) begin
            a_diff_reg <= hi - lo;
            a_sum_reg  <= {1'b0, hi} + {1'b0, lo};
            a_sect_reg <= sect;
            a_hued_reg <= hue_d;
            // red sector with green above blue keeps green - blue without the 6x wrap
            a_gt_reg   <= (hi == r) && (g > b) && (b != hi) && (g != hi);
        end
    end

    // Stage B: numerators and divisors.
    rthc_pkg::cell_data_t b_next, b_reg;
    logic [10:0] hnum;
    logic [10:0] span;
    logic [10:0] hued_x;
    logic [8:0]  sden;

    always_comb begin
        span   = 11'(a_diff_reg) * 11'd6;
        hued_x = {{2{a_hued_reg[8]}}, a_hued_reg};
        unique case (a_sect_reg)
            rthc_pkg::SECT_BLUE:  hnum = 11'(a_diff_reg) * 11'd4 + hued_x;
            rthc_pkg::SECT_GREEN: hnum = 11'(a_diff_reg) * 11'd2 + hued_x;
            default:              hnum = a_gt_reg ? hued_x : span + hued_x;
        endcase
        sden = (a_sum_reg <= 9'd255) ? a_sum_reg : 9'(10'd510 - 10'(a_sum_reg));
        b_next.valid     = a_valid_reg;
        b_next.lightness = a_sum_reg[8:1];
        b_next.hue.rem   = '0;
        b_next.hue.quo   = '0;
        b_next.sat.rem   = '0;
        b_next.sat.quo   = '0;
        if (a_diff_reg == 8'd0) begin
            // grey: force zero quotients with a zero numerator
            b_next.hue.num = '0;
            b_next.hue.den = 11'd1;
            b_next.sat.num = '0;
            b_next.sat.den = 11'd1;
        end else begin
            b_next.hue.num = 19'(hnum) * 19'd255;
            b_next.hue.den = span;
            b_next.sat.num = 19'(a_diff_reg) * 19'd255;
            b_next.sat.den = 11'(sden);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_reg.valid <= 1'b0;
        end else if (advance) begin
            b_reg.valid <= b_next.valid;
        end
        if (advance) begin
            b_reg.lightness <= b_next.lightness;
            b_reg.hue       <= b_next.hue;
            b_reg.sat       <= b_next.sat;
        end
    end

    rthc_pkg::cell_data_t chain [NCELL+1];
    assign chain[0] = b_reg;

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        rthc_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .in_data  (chain[i]),
            .out_data (chain[i+1])
        );
    end

    assign m_axis_tvalid = chain[NCELL].valid;
    assign m_axis_tdata  = {chain[NCELL].sat.quo, chain[NCELL].lightness,
                            chain[NCELL].hue.quo};

endmodule

// File: rtl/rthc_div_cell.sv
// One restoring-division step applied to the hue and saturation lanes.
// Uses rthc_pkg for the lane record.
module rthc_div_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  rthc_pkg::cell_data_t in_data,
    output rthc_pkg::cell_data_t out_data
);

    rthc_pkg::cell_data_t data_reg;
    rthc_pkg::cell_data_t data_next;

    function automatic rthc_pkg::div_lane_t div_step(input rthc_pkg::div_lane_t lane);
        rthc_pkg::div_lane_t r;
        logic [rthc_pkg::DEN_W+1:0] trial;
        logic [rthc_pkg::DEN_W+1:0] sub;
        r     = lane;
        trial = {lane.rem, lane.num[rthc_pkg::NUM_W-1]};
        sub   = trial - {2'b00, lane.den};
        r.num = {lane.num[rthc_pkg::NUM_W-2:0], 1'b0};
        if (trial >= {2'b00, lane.den}) begin
            r.rem = sub[rthc_pkg::DEN_W:0];
            r.quo = {lane.quo[rthc_pkg::QUO_W-2:0], 1'b1};
        end else begin
            r.rem = trial[rthc_pkg::DEN_W:0];
            r.quo = {lane.quo[rthc_pkg::QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb begin
        data_next     = in_data;
        data_next.hue = div_step(in_data.hue);
        data_next.sat = div_step(in_data.sat);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg.valid <= 1'b0;
        end else if (advance) begin
            data_reg.valid <= data_next.valid;
        end
        if (advance) begin
            data_reg.lightness <= data_next.lightness;
            data_reg.hue       <= data_next.hue;
            data_reg.sat       <= data_next.sat;
        end
    end

    assign out_data = data_reg;

endmodule
